/* hw/rtl/mfpr_pkg.sv */
// shared types, codes and constants of the marker framed packet receiver
`timescale 1ns / 1ps

package mfpr_pkg;

    localparam int BYTE_W          = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_COUNT_W     = 32;
    localparam int EVENT_W         = 2;
    localparam int CFG_INDEX_W     = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 2 * BYTE_W + 2 * OUT_COUNT_W;
    localparam int M_TUSER_W       = EVENT_W + 1;

    localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ACCEPT   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_MISMATCH = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TYPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESC_TYPE = 2'd2;

    localparam logic [BYTE_W-1:0] MARKER_RST    = 8'hA5;
    localparam logic [BYTE_W-1:0] DATA_TYPE_RST = 8'h01;
    localparam logic [BYTE_W-1:0] DESC_TYPE_RST = 8'h02;

    typedef struct packed {
        logic [BYTE_W-1:0] marker_value;
        logic [BYTE_W-1:0] data_type_code;
        logic [BYTE_W-1:0] desc_type_code;
    } cfg_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] bad_packets;
        logic [OUT_COUNT_W-1:0] good_packets;
        logic [BYTE_W-1:0]      byte_offset;
        logic [BYTE_W-1:0]      payload_byte;
        logic                   packet_kind;
        logic [EVENT_W-1:0]     event_res;
    } result_t;

endpackage

/* hw/rtl/mfpr_cfg_regs.sv */
// configuration register bank of the marker framed packet receiver
`timescale 1ns / 1ps

module mfpr_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mfpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mfpr_pkg::BYTE_W-1:0]        cfg_data,
    output mfpr_pkg::cfg_t                     cfg
);
    import mfpr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MARKER:    cfg_next.marker_value   = cfg_data;
                CFG_DATA_TYPE: cfg_next.data_type_code = cfg_data;
                CFG_DESC_TYPE: cfg_next.desc_type_code = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.marker_value   <= MARKER_RST;
            cfg_reg.data_type_code <= DATA_TYPE_RST;
            cfg_reg.desc_type_code <= DESC_TYPE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/mfpr_parser.sv */
// framing state machine, xor checksum and packet counters
`timescale 1ns / 1ps

module mfpr_parser #(
    parameter int COUNT_WIDTH = mfpr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [mfpr_pkg::BYTE_W-1:0]   rx_byte,
    input  mfpr_pkg::cfg_t                cfg,
    output logic                          res_valid,
    output mfpr_pkg::result_t             res
);
    import mfpr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]             phase_reg, phase_next;
    logic                   marker_seen_reg, marker_seen_next;
    logic                   kind_reg, kind_next;
    logic [BYTE_W-1:0]      length_reg, length_next;
    logic [BYTE_W-1:0]      offset_reg, offset_next;
    logic [BYTE_W-1:0]      check_reg, check_next;
    logic [COUNT_WIDTH-1:0] good_count_reg, good_count_next;
    logic [COUNT_WIDTH-1:0] bad_count_reg, bad_count_next;

    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    always_comb begin
        phase_next       = phase_reg;
        marker_seen_next = marker_seen_reg;
        kind_next        = kind_reg;
        length_next      = length_reg;
        offset_next      = offset_reg;
        check_next       = check_reg;
        good_count_next  = good_count_reg;
        bad_count_next   = bad_count_reg;
        res_valid        = 1'b0;
        res.event_res    = EV_PAYLOAD;
        res.payload_byte = '0;
        res.byte_offset  = '0;

        unique case (phase_reg)
            PH_LEN: begin
                length_next = rx_byte;
                offset_next = '0;
                check_next  = '0;
                phase_next  = PH_DATA;
            end
            PH_DATA: begin
                res_valid = 1'b1;
                if (offset_reg < length_reg) begin
                    check_next       = (offset_reg == '0) ? rx_byte : (check_reg ^ rx_byte);
                    res.payload_byte = rx_byte;
                    res.byte_offset  = offset_reg;
                    offset_next      = offset_reg + 8'd1;
                end else begin
                    if (check_reg == rx_byte) begin
                        good_count_next = good_count_reg + COUNT_ONE;
                        res.event_res   = EV_ACCEPT;
                    end else begin
                        bad_count_next  = bad_count_reg + COUNT_ONE;
                        res.event_res   = EV_MISMATCH;
                    end
                    phase_next       = PH_HUNT;
                    marker_seen_next = 1'b0;
                    offset_next      = '0;
                    check_next       = '0;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (rx_byte == cfg.marker_value) begin
                    marker_seen_next = 1'b1;
                end else if (marker_seen_reg) begin
                    if (rx_byte == cfg.data_type_code) begin
                        kind_next  = 1'b0;
                        phase_next = PH_LEN;
                    end else if (rx_byte == cfg.desc_type_code) begin
                        kind_next  = 1'b1;
                        phase_next = PH_LEN;
                    end else begin
                        marker_seen_next = 1'b0;
                        offset_next      = '0;
                        check_next       = '0;
                    end
                end
            end
        endcase

        res.packet_kind  = kind_reg;
        res.good_packets = OUT_COUNT_W'(good_count_next);
        res.bad_packets  = OUT_COUNT_W'(bad_count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            marker_seen_reg <= 1'b0;
            kind_reg        <= 1'b0;
            length_reg      <= '0;
            offset_reg      <= '0;
            check_reg       <= '0;
            good_count_reg  <= '0;
            bad_count_reg   <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            marker_seen_reg <= marker_seen_next;
            kind_reg        <= kind_next;
            length_reg      <= length_next;
            offset_reg      <= offset_next;
            check_reg       <= check_next;
            good_count_reg  <= good_count_next;
            bad_count_reg   <= bad_count_next;
        end
    end

endmodule

/* hw/rtl/mfpr_out_stage.sv */
// result register between the parser and the output stream
`timescale 1ns / 1ps

module mfpr_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic                                res_valid,
    input  mfpr_pkg::result_t                   res,
    output logic                                take_ready,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mfpr_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // payload_byte, byte_offset, good_packets, bad_packets
    output logic [mfpr_pkg::M_TUSER_W-1:0]      m_axis_tuser   // event_res, packet_kind
);
    import mfpr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign take_ready    = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.bad_packets, data_reg.good_packets,
                            data_reg.byte_offset, data_reg.payload_byte};
    assign m_axis_tuser  = {data_reg.packet_kind, data_reg.event_res};

    always_comb begin
        valid_next = valid_reg;
        if (step && res_valid) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

/* hw/rtl/marker_framed_packet_receiver.sv */
// top level of the marker framed packet receiver
// a payload or end-of-packet result is registered and appears in the cycle after its input transaction
// throughput: one byte per cycle, limited only by output back-pressure on the result register
// marker, type and length bytes and bytes while hunting give no result transaction
// reset: synchronous active-low aresetn clears framing state, counters and output valid,
// and loads the register defaults (marker a5, data type 01, description type 02)
`timescale 1ns / 1ps

module marker_framed_packet_receiver #(
    parameter int COUNT_WIDTH = mfpr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mfpr_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mfpr_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // payload_byte, byte_offset, good_packets, bad_packets
    output logic [mfpr_pkg::M_TUSER_W-1:0]      m_axis_tuser,  // event_res, packet_kind
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mfpr_pkg::BYTE_W-1:0]         cfg_data
);
    import mfpr_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    take_ready;
    logic    step;

    assign s_axis_tready = take_ready;
    assign step          = s_axis_tvalid && take_ready;

    mfpr_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfpr_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_axis_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    mfpr_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .res_valid     (res_valid),
        .res           (res),
        .take_ready    (take_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    a_end_fields_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[EVENT_W-1:0] != EV_PAYLOAD))
            |-> (m_axis_tdata[2*BYTE_W-1:0] == '0))
        else $error("end-of-packet result carries payload fields");

    a_event_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[EVENT_W-1:0] == EV_PAYLOAD
                           || m_axis_tuser[EVENT_W-1:0] == EV_ACCEPT
                           || m_axis_tuser[EVENT_W-1:0] == EV_MISMATCH))
        else $error("undefined event code on result");

    a_drain : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !step) |=> !m_axis_tvalid)
        else $error("result repeated after transaction");

    a_no_stall_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");
`endif

endmodule

/* tb/sv/marker_framed_packet_receiver_tb.sv */
// self-checking testbench: random framed byte streams against a cycle-free deframer predictor
`timescale 1ns / 1ps

module marker_framed_packet_receiver_tb;

    import mfpr_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 275;
    localparam int          SETTLE       = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {FR_HUNT, FR_LEN, FR_DATA} frame_phase_e;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic [M_TUSER_W-1:0]     m_axis_tuser;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index     = '0;
    logic [BYTE_W-1:0]        cfg_data      = '0;

    // predictor state and register copy
    logic [BYTE_W-1:0]        cfg_marker    = MARKER_RST;
    logic [BYTE_W-1:0]        cfg_data_type = DATA_TYPE_RST;
    logic [BYTE_W-1:0]        cfg_desc_type = DESC_TYPE_RST;
    frame_phase_e             fr_phase      = FR_HUNT;
    logic                     fr_marker_hit = 1'b0;
    logic                     fr_kind       = 1'b0;
    logic [BYTE_W-1:0]        fr_len        = '0;
    logic [BYTE_W-1:0]        fr_off        = '0;
    logic [BYTE_W-1:0]        fr_xor        = '0;
    logic [OUT_COUNT_W-1:0]   good_cnt      = '0;
    logic [OUT_COUNT_W-1:0]   bad_cnt       = '0;

    logic [BYTE_W-1:0]        pending_bytes[$];
    result_t                  expected_results[$];

    bit                       in_taken      = 1'b0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       hold_requests = 0;
    int                       err_count     = 0;
    int                       bytes_in      = 0;
    int                       results_seen  = 0;
    int                       settings_used = 0;
    int                       items_queued  = 0;
    int                       cycle_count   = 0;

    marker_framed_packet_receiver u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // payload_byte, byte_offset, good_packets, bad_packets
        .m_axis_tuser  (m_axis_tuser),   // event_res, packet_kind
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic restart_hunt();
        fr_phase      = FR_HUNT;
        fr_marker_hit = 1'b0;
        fr_off        = '0;
        fr_xor        = '0;
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        case (fr_phase)
            FR_LEN: begin
                fr_len   = b;
                fr_off   = '0;
                fr_xor   = '0;
                fr_phase = FR_DATA;
            end
            FR_DATA: begin
                r.packet_kind = fr_kind;
                if (fr_off < fr_len) begin
                    fr_xor         = (fr_off == 0) ? b : (fr_xor ^ b);
                    r.event_res    = EV_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_offset  = fr_off;
                    fr_off         = fr_off + 1'b1;
                end else begin
                    if (fr_xor == b) begin
                        good_cnt    = good_cnt + 1'b1;
                        r.event_res = EV_ACCEPT;
                    end else begin
                        bad_cnt     = bad_cnt + 1'b1;
                        r.event_res = EV_MISMATCH;
                    end
                    restart_hunt();
                end
                r.good_packets = good_cnt;
                r.bad_packets  = bad_cnt;
                expected_results.push_back(r);
            end
            default: begin
                fr_phase = FR_HUNT;
                if (b == cfg_marker) begin
                    fr_marker_hit = 1'b1;
                end else if (fr_marker_hit) begin
                    if (b == cfg_data_type) begin
                        fr_kind  = 1'b0;
                        fr_phase = FR_LEN;
                    end else if (b == cfg_desc_type) begin
                        fr_kind  = 1'b1;
                        fr_phase = FR_LEN;
                    end else begin
                        restart_hunt();
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // input, config and result transactions seen at the rising edge
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("marker_framed_packet_receiver regression: fail");
            $finish;
        end
        in_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MARKER:    cfg_marker    = cfg_data;
                    CFG_DATA_TYPE: cfg_data_type = cfg_data;
                    CFG_DESC_TYPE: cfg_desc_type = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                bytes_in++;
                predict_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.event_res    = m_axis_tuser[EVENT_W-1:0];
                got.packet_kind  = m_axis_tuser[EVENT_W];
                got.payload_byte = m_axis_tdata[BYTE_W-1:0];
                got.byte_offset  = m_axis_tdata[2*BYTE_W-1:BYTE_W];
                got.good_packets = m_axis_tdata[2*BYTE_W+OUT_COUNT_W-1:2*BYTE_W];
                got.bad_packets  = m_axis_tdata[M_TDATA_W-1:2*BYTE_W+OUT_COUNT_W];
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    check_field("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(got.payload_byte));
                    check_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
                    check_field("good_packets", want.good_packets, got.good_packets);
                    check_field("bad_packets",  want.bad_packets,  got.bad_packets);
                end
            end
        end
    end

    // byte driver
    always @(negedge aclk) begin
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (!s_axis_tvalid || in_taken) begin
            nxt_valid = 1'b0;
            if (aresetn && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data  = pending_bytes.pop_front();
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // result back-pressure, with a long hold-off on request
    always @(negedge aclk) begin
        static int hold_left = 0;
        static int holds_done = 0;
        if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        items_queued++;
    endtask

    task automatic queue_packet(input logic [BYTE_W-1:0] type_code, input int len,
                                input bit sum_ok);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        repeat ($urandom_range(1, 3)) push_byte(cfg_marker);
        push_byte(type_code);
        push_byte(len[BYTE_W-1:0]);
        for (int i = 0; i < len; i++) begin
            b   = BYTE_W'($urandom);
            sum = sum ^ b;
            push_byte(b);
        end
        push_byte(sum_ok ? sum : (sum ^ BYTE_W'($urandom_range(1, 255))));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [BYTE_W-1:0] mk, input logic [BYTE_W-1:0] dt,
                                 input logic [BYTE_W-1:0] ds);
        wait_drained();
        write_reg(CFG_MARKER, mk);
        write_reg(CFG_DATA_TYPE, dt);
        write_reg(CFG_DESC_TYPE, ds);
        write_reg(CFG_UNUSED, BYTE_W'($urandom));
        settings_used++;
    endtask

    task automatic random_traffic(input int goal);
        logic [BYTE_W-1:0] b;
        int                pick;
        int                len;
        items_queued = 0;
        while (items_queued < goal) begin
            pick = $urandom_range(99);
            len  = $urandom_range(49);
            len  = (len == 0) ? 255 : (len <= 5) ? 0 : $urandom_range(1, 12);
            if (pick < 70) begin
                queue_packet($urandom_range(1) ? cfg_desc_type : cfg_data_type, len,
                             $urandom_range(9) != 0);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5)) push_byte(BYTE_W'($urandom));
            end else if (pick < 93) begin
                push_byte(cfg_marker);
                do b = BYTE_W'($urandom);
                while (b == cfg_marker || b == cfg_data_type || b == cfg_desc_type);
                push_byte(b);
            end else begin
                // truncated packet, the next bytes land in its payload
                push_byte(cfg_marker);
                push_byte(cfg_data_type);
                push_byte(BYTE_W'($urandom_range(2, 12)));
                repeat ($urandom_range(0, 1)) push_byte(BYTE_W'($urandom));
            end
        end
    endtask

    task automatic random_setting(output logic [BYTE_W-1:0] mk, output logic [BYTE_W-1:0] dt,
                                  output logic [BYTE_W-1:0] ds);
        mk = BYTE_W'($urandom);
        do dt = BYTE_W'($urandom); while (dt == mk);
        do ds = BYTE_W'($urandom); while (ds == mk);
    endtask

    initial begin
        logic [BYTE_W-1:0] mk;
        logic [BYTE_W-1:0] dt;
        logic [BYTE_W-1:0] ds;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // directed frames with the reset register values
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5); push_byte(8'h01); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hA5); push_byte(8'hA5); push_byte(8'h02); push_byte(8'h01);
        push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'hA5); push_byte(8'h01); push_byte(8'h02); push_byte(8'h10);
        push_byte(8'h20); push_byte(8'h31);
        push_byte(8'hA5); push_byte(8'h07);
        push_byte(8'h5A);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_setting(8'h00, 8'hFF, 8'h80);
                2: apply_setting(8'hFF, 8'h00, 8'h00);
                4: apply_setting(MARKER_RST, DATA_TYPE_RST, DESC_TYPE_RST);
                default: begin
                    random_setting(mk, dt, ds);
                    apply_setting(mk, dt, ds);
                end
            endcase
            send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 78 : 0;
            recv_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 14 : 0;
            if (ph == 2)
                hold_requests++;
            random_traffic(PHASE_ITEMS);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("covered %0d input and %0d result transactions over %0d register settings",
                 bytes_in, results_seen, settings_used);
        $display("packets with good checksum %0d, with bad checksum %0d", good_cnt, bad_cnt);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("marker_framed_packet_receiver regression: pass");
        end else begin
            $display("marker_framed_packet_receiver regression: fail");
        end
        $finish;
    end

endmodule

/* marker_framed_packet_receiver.f */
hw/rtl/mfpr_pkg.sv
hw/rtl/mfpr_cfg_regs.sv
hw/rtl/mfpr_parser.sv
hw/rtl/mfpr_out_stage.sv
hw/rtl/marker_framed_packet_receiver.sv
tb/sv/marker_framed_packet_receiver_tb.sv
